>>> sv/flm_pkg.sv
`default_nettype none
package flm_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int NUM_BLOCKS = 4;

  // inodes 0 and 1 are never handed out by a refill
  localparam int SCAN_FIRST = 2;
  localparam int SCAN_LIMIT = (NUM_BLOCKS * 16 > 64) ? 64 : NUM_BLOCKS * 16;

  localparam int INODE_W  = 6;
  localparam int NUM_INODES = 64;
  localparam int PTR_W    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int LCOUNT_W = 5;
  localparam int SCAN_W   = INODE_W + 1;
  localparam int UPC_W    = 4;

  localparam logic EMPTY_MARK = 1'b1;

  localparam logic [1:0] OP_SET_MAP = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_REFILL  = 2'd3;

  typedef enum logic [3:0] {
    A_NOP,
    A_MAP_WR,
    A_CLR,
    A_SCAN,
    A_RD_FRONT,
    A_POP,
    A_PUSH,
    A_RD_LAST,
    A_REPL
  } act_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_CNT_NZ,
    C_CNT_ZERO,
    C_FULL,
    C_SCAN_MORE
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic scan_more;
  } stat_t;

endpackage
`default_nettype wire

>>> sv/flm_seq.sv
`default_nettype none
module flm_seq import flm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [1:0] op,
  input  wire stat_t      stat,
  output ctrl_t           ctrl,
  output logic            busy
);

  // program entry points
  localparam logic [UPC_W-1:0] U_MAP    = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_ALLOC  = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_AREF   = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_ASCAN  = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_ATAKE  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_ANONE  = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_FREE   = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_FFULL  = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_REFILL = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_RSCAN  = UPC_W'(13);

  logic             running;
  logic [UPC_W-1:0] upc;
  ctrl_t            word;
  logic             taken;

  function automatic logic [UPC_W-1:0] entry_of(input logic [1:0] code);
    logic [UPC_W-1:0] e;
    unique case (code)
      OP_SET_MAP: e = U_MAP;
      OP_ALLOC:   e = U_ALLOC;
      OP_FREE:    e = U_FREE;
      OP_REFILL:  e = U_REFILL;
      default:    e = U_MAP;
    endcase
    return e;
  endfunction

  // microcode rom
  always_comb begin
    unique case (upc)
      UPC_W'(0):  word = '{act: A_MAP_WR,   cond: C_NONE,      target: U_MAP,   last: 1'b1};
      UPC_W'(1):  word = '{act: A_NOP,      cond: C_CNT_NZ,    target: U_ATAKE, last: 1'b0};
      UPC_W'(2):  word = '{act: A_CLR,      cond: C_NONE,      target: U_AREF,  last: 1'b0};
      UPC_W'(3):  word = '{act: A_SCAN,     cond: C_SCAN_MORE, target: U_ASCAN, last: 1'b0};
      UPC_W'(4):  word = '{act: A_NOP,      cond: C_CNT_ZERO,  target: U_ANONE, last: 1'b0};
      UPC_W'(5):  word = '{act: A_RD_FRONT, cond: C_NONE,      target: U_ATAKE, last: 1'b0};
      UPC_W'(6):  word = '{act: A_POP,      cond: C_NONE,      target: U_ATAKE, last: 1'b1};
      UPC_W'(7):  word = '{act: A_NOP,      cond: C_NONE,      target: U_ANONE, last: 1'b1};
      UPC_W'(8):  word = '{act: A_NOP,      cond: C_FULL,      target: U_FFULL, last: 1'b0};
      UPC_W'(9):  word = '{act: A_PUSH,     cond: C_NONE,      target: U_FREE,  last: 1'b1};
      UPC_W'(10): word = '{act: A_RD_LAST,  cond: C_NONE,      target: U_FFULL, last: 1'b0};
      UPC_W'(11): word = '{act: A_REPL,     cond: C_NONE,      target: U_FFULL, last: 1'b1};
      UPC_W'(12): word = '{act: A_CLR,      cond: C_NONE,      target: U_REFILL, last: 1'b0};
      UPC_W'(13): word = '{act: A_SCAN,     cond: C_SCAN_MORE, target: U_RSCAN, last: 1'b0};
      UPC_W'(14): word = '{act: A_NOP,      cond: C_NONE,      target: U_REFILL, last: 1'b1};
      default:    word = '{act: A_NOP,      cond: C_NONE,      target: U_MAP,   last: 1'b1};
    endcase
  end

  always_comb begin
    case (word.cond)
      C_CNT_NZ:    taken = !stat.cnt_zero;
      C_CNT_ZERO:  taken = stat.cnt_zero;
      C_FULL:      taken = stat.full;
      C_SCAN_MORE: taken = stat.scan_more;
      default:     taken = 1'b0;
    endcase
  end

  assign ctrl = running ? word
                        : ctrl_t'{act: A_NOP, cond: C_NONE, target: U_MAP, last: 1'b0};
  assign busy = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      upc     <= U_MAP;
    end else if (running) begin
      if (word.last) begin
        running <= 1'b0;
      end else if (taken) begin
        upc <= word.target;
      end else begin
        upc <= upc + UPC_W'(1);
      end
    end else if (accept) begin
      running <= 1'b1;
      upc     <= entry_of(op);
    end
  end

endmodule
`default_nettype wire

>>> sv/flm_dp.sv
`default_nettype none
module flm_dp import flm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [INODE_W-1:0]  inode_number,
  input  wire logic                is_empty,
  input  wire ctrl_t               ctrl,
  output stat_t                    stat,
  output logic                     done,
  output logic [INODE_W-1:0]       inode_out,
  output logic                     valid_res,
  output logic [LCOUNT_W-1:0]      list_count
);

  localparam int LAST_W = CNT_W + 1;

  logic [INODE_W-1:0]    list_mem [LIST_DEPTH];
  logic [INODE_W-1:0]    rdata;
  logic [PTR_W-1:0]      front;
  logic [CNT_W-1:0]      count;
  logic [NUM_INODES-1:0] empty_map;
  logic [SCAN_W-1:0]     scan;
  logic [INODE_W-1:0]    ino_r;
  logic                  emp_r;

  logic [PTR_W-1:0]      front_next;
  logic [CNT_W-1:0]      count_next;
  logic [NUM_INODES-1:0] empty_map_next;
  logic [SCAN_W-1:0]     scan_next;
  logic                  we;
  logic [PTR_W-1:0]      waddr;
  logic [INODE_W-1:0]    wdata;
  logic                  re;
  logic [PTR_W-1:0]      raddr;

  logic [PTR_W-1:0]      front_inc;
  logic [PTR_W-1:0]      front_dec;
  logic [LAST_W-1:0]     last_sum;
  logic [PTR_W-1:0]      last_idx;
  logic                  found;
  logic [INODE_W-1:0]    found_idx;

  assign front_inc = (front == PTR_W'(LIST_DEPTH - 1)) ? '0 : front + PTR_W'(1);
  assign front_dec = (front == '0) ? PTR_W'(LIST_DEPTH - 1) : front - PTR_W'(1);

  // wrap of front + count - 1, stays below twice the depth
  always_comb begin
    last_sum = LAST_W'(front) + LAST_W'(count) - LAST_W'(1);
    if (last_sum >= LAST_W'(LIST_DEPTH)) begin
      last_sum = last_sum - LAST_W'(LIST_DEPTH);
    end
    last_idx = PTR_W'(last_sum);
  end

  // priority encoder: lowest empty inode at or above the scan position
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < NUM_INODES; i++) begin
      if (!found && empty_map[i] && i >= SCAN_FIRST && i < SCAN_LIMIT
          && SCAN_W'(i) >= scan) begin
        found     = 1'b1;
        found_idx = INODE_W'(i);
      end
    end
  end

  assign stat.cnt_zero  = (count == '0);
  assign stat.full      = (count == CNT_W'(LIST_DEPTH));
  assign stat.scan_more = found && (count != CNT_W'(LIST_DEPTH - 1));

  always_comb begin
    front_next     = front;
    count_next     = count;
    empty_map_next = empty_map;
    scan_next      = scan;
    we             = 1'b0;
    waddr          = front;
    wdata          = ino_r;
    re             = 1'b0;
    raddr          = front;
    unique case (ctrl.act)
      A_MAP_WR: empty_map_next[ino_r] = (emp_r == EMPTY_MARK);
      A_CLR: begin
        front_next = '0;
        count_next = '0;
        scan_next  = SCAN_W'(SCAN_FIRST);
      end
      A_SCAN: begin
        if (found) begin
          we         = 1'b1;
          waddr      = PTR_W'(count);
          wdata      = found_idx;
          count_next = count + CNT_W'(1);
          scan_next  = SCAN_W'(found_idx) + SCAN_W'(1);
        end
      end
      A_RD_FRONT: re = 1'b1;
      A_POP: begin
        front_next = front_inc;
        count_next = count - CNT_W'(1);
      end
      A_PUSH: begin
        we         = 1'b1;
        waddr      = front_dec;
        front_next = front_dec;
        count_next = count + CNT_W'(1);
      end
      A_RD_LAST: begin
        re    = 1'b1;
        raddr = last_idx;
      end
      A_REPL: begin
        // remembered inode is kept only if the freed one is not smaller
        waddr = last_idx;
        we    = (ino_r < rdata);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      list_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= list_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      empty_map <= '1;
      scan      <= SCAN_W'(SCAN_FIRST);
      done      <= 1'b0;
    end else begin
      front     <= front_next;
      count     <= count_next;
      empty_map <= empty_map_next;
      scan      <= scan_next;
      done      <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ino_r <= inode_number;
      emp_r <= is_empty;
    end
    if (ctrl.last) begin
      inode_out  <= (ctrl.act == A_POP) ? rdata : '0;
      valid_res  <= (ctrl.act == A_POP);
      list_count <= LCOUNT_W'(count_next);
    end
  end

endmodule
`default_nettype wire

>>> sv/free_inode_list_manager.sv
// Free inode list manager. An item is taken when start is high and busy is low;
// its single result appears on inode_out, valid_res and list_count for exactly
// one cycle with done high, and must be captured then since there is no
// backpressure. Busy stays high from the accept until the done cycle. A map
// write sets one map bit, a free pushes the inode onto the front of the list,
// or replaces the last entry if smaller when full. A refill (op 3, or an
// allocate that finds the list empty) walks the map with a priority encoder,
// one list entry per cycle, until nothing more is found or the list fills;
// an allocate pops the front entry, if any. The next item can be started in
// the same cycle as done.
`default_nettype none
module free_inode_list_manager import flm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op,
  input  wire logic [INODE_W-1:0]  inode_number,
  input  wire logic                is_empty,
  output logic                     done,
  output logic [INODE_W-1:0]       inode_out,
  output logic                     valid_res,
  output logic [LCOUNT_W-1:0]      list_count
);

  logic  accept;
  ctrl_t ctrl;
  stat_t stat;

  assign accept = start && !busy;

  flm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  flm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .inode_number (inode_number),
    .is_empty     (is_empty),
    .ctrl         (ctrl),
    .stat         (stat),
    .done         (done),
    .inode_out    (inode_out),
    .valid_res    (valid_res),
    .list_count   (list_count)
  );

endmodule
`default_nettype wire
